/* rtl/cdpa_pkg.sv */
// shared types, constants and the output scaling function of the complex mac block
package cdpa_pkg;

  localparam int unsigned SampleWidth       = 16;
  localparam int unsigned AccWidth          = 32;
  localparam int unsigned ShiftWidth        = 5;
  localparam int unsigned QueueDepthDefault = 4;

  typedef logic signed [SampleWidth-1:0] sample_t;
  typedef logic signed [AccWidth-1:0]    acc_t;
  typedef logic [ShiftWidth-1:0]         shift_t;

  // one classified item: per-item real and imaginary partial sums plus the last flag
  typedef struct packed {
    acc_t re;
    acc_t im;
    logic last;
  } prod_t;

  // write side of the queue
  typedef struct packed {
    logic  push;
    prod_t data;
  } q_wr_t;

  // read side of the queue
  typedef struct packed {
    logic  valid;
    prod_t data;
  } q_rd_t;

  localparam acc_t SatMax = acc_t'(32767);
  localparam acc_t SatMin = -acc_t'(32768);

  // arithmetic right shift, then saturate to int16
  function automatic sample_t shift_sat16(input acc_t acc, input shift_t sh);
    acc_t r;
    r = acc >>> sh;
    if (r > SatMax) begin
      return sample_t'(SatMax);
    end else if (r < SatMin) begin
      return sample_t'(SatMin);
    end
    return r[SampleWidth-1:0];
  endfunction

endpackage

/* rtl/cdpa_if.sv */
// valid/ready channel interfaces for sample pairs and results
interface cdpa_in_if;
  logic              valid;
  logic              ready;
  cdpa_pkg::sample_t x_real;
  cdpa_pkg::sample_t x_imag;
  cdpa_pkg::sample_t y_real;
  cdpa_pkg::sample_t y_imag;
  logic              last_element;

  modport source (output valid, output x_real, output x_imag, output y_real,
                  output y_imag, output last_element, input ready);
  modport sink (input valid, input x_real, input x_imag, input y_real,
                input y_imag, input last_element, output ready);
endinterface

interface cdpa_out_if;
  logic              valid;
  logic              ready;
  cdpa_pkg::sample_t sum_real;
  cdpa_pkg::sample_t sum_imag;

  modport source (output valid, output sum_real, output sum_imag, input ready);
  modport sink (input valid, input sum_real, input sum_imag, output ready);
endinterface

/* rtl/cdpa_front.sv */
// front end: accepts sample pairs, registers the four products, pushes partial sums
module cdpa_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  cdpa_in_if.sink           in_i,
  input  logic              q_full_i,
  output cdpa_pkg::q_wr_t   q_wr_o
);

  logic              p_valid_q, p_valid_d;
  cdpa_pkg::acc_t    rr_q, in_q, ri_q, ir_q;
  logic              last_q;
  cdpa_pkg::sample_t y_neg;
  logic              accept;
  logic              advance;

  assign advance   = p_valid_q && !q_full_i;
  assign in_i.ready = !p_valid_q || !q_full_i;
  assign accept    = in_i.valid && in_i.ready;

  // 16-bit negation wraps, so the most negative value stays as it is
  assign y_neg = ~in_i.y_imag + cdpa_pkg::sample_t'(1);

  always_comb begin
    p_valid_d = p_valid_q;
    if (accept) begin
      p_valid_d = 1'b1;
    end else if (advance) begin
      p_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else begin
      p_valid_q <= p_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rr_q   <= cdpa_pkg::acc_t'(in_i.x_real) * cdpa_pkg::acc_t'(in_i.y_real);
      in_q   <= cdpa_pkg::acc_t'(in_i.x_imag) * cdpa_pkg::acc_t'(y_neg);
      ri_q   <= cdpa_pkg::acc_t'(in_i.x_real) * cdpa_pkg::acc_t'(in_i.y_imag);
      ir_q   <= cdpa_pkg::acc_t'(in_i.x_imag) * cdpa_pkg::acc_t'(in_i.y_real);
      last_q <= in_i.last_element;
    end
  end

  always_comb begin
    q_wr_o.push      = p_valid_q;
    q_wr_o.data.re   = rr_q + in_q;
    q_wr_o.data.im   = ri_q + ir_q;
    q_wr_o.data.last = last_q;
  end

endmodule

/* rtl/cdpa_queue.sv */
// short fifo between front and back ends
module cdpa_queue #(
  parameter int unsigned Depth = cdpa_pkg::QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cdpa_pkg::q_wr_t q_wr_i,
  output logic            full_o,
  input  logic            pop_i,
  output cdpa_pkg::q_rd_t q_rd_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  cdpa_pkg::prod_t mem_q [Depth];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            push_ok, pop_ok;

  assign full_o        = (cnt_q == CW'(Depth));
  assign q_rd_o.valid  = (cnt_q != '0);
  assign q_rd_o.data   = mem_q[rd_ptr_q];
  assign push_ok       = q_wr_i.push && !full_o;
  assign pop_ok        = pop_i && q_rd_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    case ({push_ok, pop_ok})
      2'b10:   cnt_d = cnt_q + CW'(1);
      2'b01:   cnt_d = cnt_q - CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= q_wr_i.data;
    end
  end

endmodule

/* rtl/cdpa_back.sv */
// back end: accumulates partial sums, scales and saturates on the last item
module cdpa_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cdpa_pkg::q_rd_t   q_rd_i,
  output logic              pop_o,
  input  cdpa_pkg::shift_t  shift_i,
  cdpa_out_if.source        out_o
);

  cdpa_pkg::acc_t    acc_re_q, acc_re_d, acc_im_q, acc_im_d;
  cdpa_pkg::acc_t    sum_re, sum_im;
  cdpa_pkg::acc_t    fin_re_q, fin_im_q;
  logic              fin_valid_q, fin_valid_d;
  logic              out_valid_q, out_valid_d;
  cdpa_pkg::sample_t out_re_q, out_im_q;
  logic              fin_move, fin_free, fin_load;

  assign fin_move = fin_valid_q && (!out_valid_q || out_o.ready);
  assign fin_free = !fin_valid_q || fin_move;
  // a last item waits until the result slot can take it
  assign pop_o    = q_rd_i.valid && (!q_rd_i.data.last || fin_free);
  assign fin_load = pop_o && q_rd_i.data.last;

  assign sum_re = acc_re_q + q_rd_i.data.re;
  assign sum_im = acc_im_q + q_rd_i.data.im;

  always_comb begin
    acc_re_d    = acc_re_q;
    acc_im_d    = acc_im_q;
    fin_valid_d = fin_valid_q;
    out_valid_d = out_valid_q;
    if (pop_o) begin
      acc_re_d = q_rd_i.data.last ? '0 : sum_re;
      acc_im_d = q_rd_i.data.last ? '0 : sum_im;
    end
    if (fin_load) begin
      fin_valid_d = 1'b1;
    end else if (fin_move) begin
      fin_valid_d = 1'b0;
    end
    if (fin_move) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_re_q    <= '0;
      acc_im_q    <= '0;
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_re_q    <= acc_re_d;
      acc_im_q    <= acc_im_d;
      fin_valid_q <= fin_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      fin_re_q <= sum_re;
      fin_im_q <= sum_im;
    end
    if (fin_move) begin
      out_re_q <= cdpa_pkg::shift_sat16(fin_re_q, shift_i);
      out_im_q <= cdpa_pkg::shift_sat16(fin_im_q, shift_i);
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.sum_real = out_re_q;
  assign out_o.sum_imag = out_im_q;

endmodule

/* rtl/complex_dot_product_accumulator_top.sv */
// Complex dot product accumulator, int16 samples with 32-bit wrapping sums.
// in_i carries one sample pair per item (x_real, x_imag, y_real, y_imag,
// last_element) on valid/ready; out_o carries one result (sum_real,
// sum_imag) per vector, i.e. per item with last_element set.
// Each item adds x*y (non-conjugate) into the real and imaginary sums.
// On the last item the sums are shifted right arithmetically by
// result_shift, saturated to int16, sent out, and cleared.
// result_shift is written through cfg_we_i / cfg_wdata_i; the user must
// write it only while idle, the block does not enforce this. Throughput:
// one item per cycle unless out_o stalls, set by the front multiplier
// stage and the back-end accumulate. A result passes the product registers,
// the queue, the result slot and the output register before showing valid.
// A queue of QueueDepth entries sits between the front and back ends; when
// out_o stalls, one result waits in the output register, one more in the
// result slot, and further items fill the queue before in_i.ready drops.
// Reset clears sums, queue and valids and sets result_shift to 0.
module complex_dot_product_accumulator_top #(
  parameter int unsigned QueueDepth = cdpa_pkg::QueueDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  cdpa_pkg::shift_t cfg_wdata_i,
  cdpa_in_if.sink          in_i,
  cdpa_out_if.source       out_o
);

  cdpa_pkg::shift_t shift_q, shift_d;
  cdpa_pkg::q_wr_t  q_wr;
  cdpa_pkg::q_rd_t  q_rd;
  logic             q_full;
  logic             q_pop;

  assign shift_d = cfg_we_i ? cfg_wdata_i : shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
    end else begin
      shift_q <= shift_d;
    end
  end

  cdpa_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_wr_o   (q_wr)
  );

  cdpa_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_wr_i (q_wr),
    .full_o (q_full),
    .pop_i  (q_pop),
    .q_rd_o (q_rd)
  );

  cdpa_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .q_rd_i  (q_rd),
    .pop_o   (q_pop),
    .shift_i (shift_q),
    .out_o   (out_o)
  );

endmodule

/* bench/testbench.sv */
// self-checking bench for the complex dot product accumulator: queued driver, checking monitor
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned IdlePct    = 27;
  localparam int unsigned DrainWait  = 8;
  localparam int unsigned StallLimit = 2000;

  typedef struct {
    cdpa_pkg::sample_t xr;
    cdpa_pkg::sample_t xi;
    cdpa_pkg::sample_t yr;
    cdpa_pkg::sample_t yi;
    logic              last;
  } sample_pair_t;

  typedef struct {
    cdpa_pkg::sample_t re;
    cdpa_pkg::sample_t im;
  } dot_sum_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  cdpa_pkg::shift_t  cfg_wdata_i;

  cdpa_in_if  in_bus ();
  cdpa_out_if out_bus ();

  complex_dot_product_accumulator_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  sample_pair_t pending_pairs[$];
  dot_sum_t     expected_sums[$];
  int           pairs_left = 0;
  int           mismatches = 0;
  int           stall_cycles = 0;
  bit           calm = 1'b0;

  // own copy of the accumulators and the scaling register
  cdpa_pkg::acc_t   acc_real = '0;
  cdpa_pkg::acc_t   acc_imag = '0;
  cdpa_pkg::shift_t shift_now = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic cdpa_pkg::acc_t cross_sum(cdpa_pkg::sample_t a, cdpa_pkg::sample_t b,
                                               cdpa_pkg::sample_t c, cdpa_pkg::sample_t d);
    return cdpa_pkg::acc_t'(a) * cdpa_pkg::acc_t'(b) + cdpa_pkg::acc_t'(c) * cdpa_pkg::acc_t'(d);
  endfunction

  function automatic cdpa_pkg::sample_t scale_to_int16(cdpa_pkg::acc_t v, cdpa_pkg::shift_t sh);
    cdpa_pkg::acc_t r;
    r = v >>> sh;
    // in range when the top 17 bits are all copies of the sign
    if (&r[cdpa_pkg::AccWidth-1:cdpa_pkg::SampleWidth-1] ||
        ~|r[cdpa_pkg::AccWidth-1:cdpa_pkg::SampleWidth-1]) begin
      return r[cdpa_pkg::SampleWidth-1:0];
    end
    return r[cdpa_pkg::AccWidth-1] ? 16'sh8000 : 16'sh7fff;
  endfunction

  task automatic accumulate_pair(cdpa_pkg::sample_t xr, cdpa_pkg::sample_t xi,
                                 cdpa_pkg::sample_t yr, cdpa_pkg::sample_t yi,
                                 logic last);
    cdpa_pkg::sample_t yi_neg;
    dot_sum_t          got;
    // 16-bit negation, so the most negative value maps onto itself
    yi_neg = -yi;
    acc_real = acc_real + cross_sum(xr, yr, xi, yi_neg);
    acc_imag = acc_imag + cross_sum(xr, yi, xi, yr);
    if (last) begin
      got.re = scale_to_int16(acc_real, shift_now);
      got.im = scale_to_int16(acc_imag, shift_now);
      expected_sums.push_back(got);
      acc_real = '0;
      acc_imag = '0;
    end
  endtask

  function automatic cdpa_pkg::sample_t pick_sample();
    int unsigned mode;
    mode = $urandom_range(99);
    if (mode < 60) begin
      return cdpa_pkg::sample_t'($urandom);
    end else if (mode < 80) begin
      return cdpa_pkg::sample_t'($signed($urandom_range(511)) - 256);
    end
    case ($urandom_range(3))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      default: return 16'shffff;
    endcase
  endfunction

  task automatic push_pair(cdpa_pkg::sample_t xr, cdpa_pkg::sample_t xi,
                           cdpa_pkg::sample_t yr, cdpa_pkg::sample_t yi, logic last);
    sample_pair_t p;
    p.xr = xr;
    p.xi = xi;
    p.yr = yr;
    p.yi = yi;
    p.last = last;
    pending_pairs.push_back(p);
    pairs_left++;
  endtask

  task automatic wait_idle();
    do begin
      @(posedge clk_i);
    end while (pairs_left != 0 || expected_sums.size() != 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_shift(cdpa_pkg::shift_t v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    shift_now = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_vectors(int n_items);
    int sent;
    int len;
    int unsigned pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        len = 1;
      end else if (pick < 80) begin
        len = $urandom_range(8, 1);
      end else begin
        len = $urandom_range(20, 9);
      end
      for (int k = 0; k < len; k++) begin
        push_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                  (k == len - 1));
      end
      sent += len;
    end
  endtask

  // driver: loads the next pending item once the current one is taken
  always @(posedge clk_i or negedge rst_ni) begin
    sample_pair_t nxt;
    if (!rst_ni) begin
      in_bus.valid        <= 1'b0;
      in_bus.x_real       <= '0;
      in_bus.x_imag       <= '0;
      in_bus.y_real       <= '0;
      in_bus.y_imag       <= '0;
      in_bus.last_element <= 1'b0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (in_bus.valid) begin
        accumulate_pair(in_bus.x_real, in_bus.x_imag, in_bus.y_real, in_bus.y_imag,
                        in_bus.last_element);
        pairs_left--;
      end
      if (pending_pairs.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
        nxt = pending_pairs.pop_front();
        in_bus.x_real       <= nxt.xr;
        in_bus.x_imag       <= nxt.xi;
        in_bus.y_real       <= nxt.yr;
        in_bus.y_imag       <= nxt.yi;
        in_bus.last_element <= nxt.last;
        in_bus.valid        <= 1'b1;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // monitor: checks each item on the result side against the oldest expected sums
  always @(posedge clk_i or negedge rst_ni) begin
    dot_sum_t want;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_sums.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got real %0d imag %0d",
                   $time, out_bus.sum_real, out_bus.sum_imag);
        end else begin
          want = expected_sums.pop_front();
          if (out_bus.sum_real !== want.re) begin
            mismatches++;
            $display("%0t: sum_real expected %0d, got %0d", $time, want.re,
                     out_bus.sum_real);
          end
          if (out_bus.sum_imag !== want.im) begin
            mismatches++;
            $display("%0t: sum_imag expected %0d, got %0d", $time, want.im,
                     out_bus.sum_imag);
          end
        end
      end
      out_bus.ready <= calm || ($urandom_range(99) >= IdlePct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= StallLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, stall_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = '0;
    in_bus.valid        = 1'b0;
    in_bus.x_real       = '0;
    in_bus.x_imag       = '0;
    in_bus.y_real       = '0;
    in_bus.y_imag       = '0;
    in_bus.last_element = 1'b0;
    out_bus.ready       = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // shift 0: extremes, the wrapped negation of y_imag, per-item and accumulator wrap
    write_shift(5'd0);
    push_pair(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1);
    push_pair(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
    push_pair(16'sd0, 16'sd1, 16'sd0, 16'sh8000, 1'b1);
    push_pair(16'sd0, -16'sd1, 16'sd0, 16'sh8000, 1'b1);
    push_pair(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1);
    push_pair(16'sd3, -16'sd2, 16'sd5, 16'sd7, 1'b1);
    for (int k = 0; k < 4; k++) begin
      push_pair(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, (k == 3));
    end
    push_pair(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 1'b1);
    push_pair(-16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b1);
    wait_idle();

    write_shift(5'd31);
    push_pair(16'sh7fff, 16'sd0, 16'sh7fff, 16'sd0, 1'b1);
    push_pair(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
    push_pair(16'sd1, 16'sd0, -16'sd1, 16'sd0, 1'b1);
    wait_idle();

    write_shift(5'd15);
    push_pair(16'sh7fff, 16'sd0, 16'sh7fff, 16'sd0, 1'b0);
    push_pair(16'sh7fff, 16'sd0, 16'sh7fff, 16'sd0, 1'b1);
    wait_idle();

    write_shift(5'd16);
    random_vectors(75);
    wait_idle();

    // no idling on either side for this stretch
    calm = 1'b1;
    write_shift(5'd0);
    random_vectors(110);
    wait_idle();
    calm = 1'b0;

    write_shift(5'd31);
    random_vectors(65);
    wait_idle();

    write_shift(cdpa_pkg::shift_t'($urandom_range(30, 1)));
    random_vectors(70);
    wait_idle();

    write_shift(5'd8);
    random_vectors(65);
    wait_idle();

    write_shift(cdpa_pkg::shift_t'($urandom));
    random_vectors(65);
    wait_idle();

    if (mismatches == 0 && expected_sums.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (expected_sums.size() != 0) begin
        $display("%0t: %0d expected results never arrived", $time, expected_sums.size());
      end
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
